[design/bmh_pkg.sv]
package bmh_pkg;

	localparam int CAPACITY  = 1024;
	localparam int KEY_WIDTH = 32;

	// Port widths are fixed by the interface.
	localparam int PORT_KEY_W = 32;
	localparam int PORT_CNT_W = 11;

	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	localparam logic signed [PORT_KEY_W-1:0] EMPTY_MIN = -1;

	typedef logic signed [KEY_WIDTH-1:0] key_t;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_DELETE,
		OP_CLEAR
	} op_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_EMPTY,
		ST_FULL
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_UP_CMP,
		S_DN_LAST,
		S_DN_CMP,
		S_PUT,
		S_DONE
	} state_t;

endpackage

[design/binary_min_heap_priority_queue.sv]
// Binary min-heap of signed keys held in one on-chip memory with two read ports and one write
// port, read data registered. Each input word is an insert, a delete-minimum or a clear and
// yields one output word with status, removed key, entry count and current minimum (-1 when
// empty). An insert opens a hole at the end and moves it up one tree level per step, shifting
// each larger parent down, until it reaches the root or a parent that is not larger; a delete
// reads the last key and sinks it from the root one level per step until it reaches a leaf or
// has no smaller child, and ends at once when it empties the heap; a clear, an undefined op, a
// dropped insert and a delete on an empty heap go straight to the result. With 1024 entries the
// worst case is set by the read-compare-write loop on the memory that moves one tree level per
// cycle. The output register lets the next word be accepted while a result still waits to be
// taken; a stalled output holds the following word in its last cycle until the waiting result is taken.
module binary_min_heap_priority_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          op,
	input  logic signed [bmh_pkg::PORT_KEY_W-1:0] key_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic signed [bmh_pkg::PORT_KEY_W-1:0] removed_key,
	output logic                                removed_valid,
	output logic [bmh_pkg::PORT_CNT_W-1:0]      entry_count,
	output logic signed [bmh_pkg::PORT_KEY_W-1:0] min_key
);

	localparam int AW = bmh_pkg::ADDR_W;
	localparam int CW = bmh_pkg::CNT_W;

	bmh_pkg::state_t state_q, state_d;

	logic [1:0]       op_q;
	bmh_pkg::key_t    key_q, key_d;
	logic [CW-1:0]    hole_q, hole_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	bmh_pkg::status_t stat_q, stat_d;
	bmh_pkg::key_t    rem_q, rem_d;
	logic             rem_vld_q, rem_vld_d;
	bmh_pkg::key_t    root_q;

	bmh_pkg::key_t heap_mem [bmh_pkg::CAPACITY];
	bmh_pkg::key_t rd_a_q, rd_b_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, rd_addr_a, rd_addr_b;
	bmh_pkg::key_t mem_wdata;

	logic                                  out_load;
	logic                                  out_valid_q;
	bmh_pkg::status_t                      out_status_q;
	logic signed [bmh_pkg::PORT_KEY_W-1:0] out_removed_q;
	logic                                  out_rvld_q;
	logic [bmh_pkg::PORT_CNT_W-1:0]        out_count_q;
	logic signed [bmh_pkg::PORT_KEY_W-1:0] out_min_q;

	logic          accept;
	logic [CW-1:0] parent;
	logic [CW:0]   left_pos;
	logic          pick_right;
	logic [CW-1:0] child_pos;
	logic [CW:0]   child2;
	bmh_pkg::key_t child_val;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != bmh_pkg::S_IDLE);

	assign parent     = hole_q >> 1;
	assign left_pos   = {hole_q, 1'b0};
	assign pick_right = (left_pos != {1'b0, cnt_q}) && (rd_b_q < rd_a_q);
	assign child_pos  = pick_right ? (left_pos[CW-1:0] + CW'(1)) : left_pos[CW-1:0];
	assign child_val  = pick_right ? rd_b_q : rd_a_q;
	assign child2     = {child_pos, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmh_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		key_d     = key_q;
		hole_d    = hole_q;
		cnt_d     = cnt_q;
		stat_d    = stat_q;
		rem_d     = rem_q;
		rem_vld_d = rem_vld_q;
		mem_we    = 1'b0;
		mem_waddr = AW'(hole_q - CW'(1));
		mem_wdata = key_q;
		rd_addr_a = '0;
		rd_addr_b = '0;
		out_load  = 1'b0;
		unique case (state_q)
			bmh_pkg::S_IDLE: begin
				if (accept) begin
					key_d     = bmh_pkg::KEY_WIDTH'(key_in);
					stat_d    = bmh_pkg::ST_OK;
					rem_d     = '0;
					rem_vld_d = 1'b0;
					state_d   = bmh_pkg::S_EXEC;
				end
			end
			bmh_pkg::S_EXEC: begin
				state_d = bmh_pkg::S_DONE;
				priority if (op_q == bmh_pkg::OP_INSERT) begin
					if (cnt_q == CW'(bmh_pkg::CAPACITY)) begin
						stat_d = bmh_pkg::ST_FULL;
					end else begin
						cnt_d  = cnt_q + CW'(1);
						hole_d = cnt_q + CW'(1);
						if (cnt_q == '0) begin
							state_d = bmh_pkg::S_PUT;
						end else begin
							// Parent of the new position cnt+1.
							rd_addr_a = AW'(((cnt_q + CW'(1)) >> 1) - CW'(1));
							state_d   = bmh_pkg::S_UP_CMP;
						end
					end
				end else if (op_q == bmh_pkg::OP_DELETE) begin
					if (cnt_q == '0) begin
						stat_d = bmh_pkg::ST_EMPTY;
					end else begin
						rem_d     = root_q;
						rem_vld_d = 1'b1;
						cnt_d     = cnt_q - CW'(1);
						if (cnt_q != CW'(1)) begin
							rd_addr_a = AW'(cnt_q - CW'(1));
							state_d   = bmh_pkg::S_DN_LAST;
						end
					end
				end else if (op_q == bmh_pkg::OP_CLEAR) begin
					cnt_d = '0;
				end else begin
					// An undefined operation leaves the heap as it is.
					cnt_d = cnt_q;
				end
			end
			bmh_pkg::S_UP_CMP: begin
				if (key_q < rd_a_q) begin
					mem_we    = 1'b1;
					mem_wdata = rd_a_q;
					hole_d    = parent;
					if (parent > CW'(1)) begin
						rd_addr_a = AW'((parent >> 1) - CW'(1));
					end else begin
						state_d = bmh_pkg::S_PUT;
					end
				end else begin
					state_d = bmh_pkg::S_PUT;
				end
			end
			bmh_pkg::S_DN_LAST: begin
				// The last key becomes the one that sinks from the root.
				key_d  = rd_a_q;
				hole_d = CW'(1);
				if (cnt_q >= CW'(2)) begin
					rd_addr_a = AW'(1);
					rd_addr_b = AW'(2);
					state_d   = bmh_pkg::S_DN_CMP;
				end else begin
					state_d = bmh_pkg::S_PUT;
				end
			end
			bmh_pkg::S_DN_CMP: begin
				if (child_val < key_q) begin
					mem_we    = 1'b1;
					mem_wdata = child_val;
					hole_d    = child_pos;
					if (child2 <= {1'b0, cnt_q}) begin
						rd_addr_a = AW'(child2 - (CW + 1)'(1));
						rd_addr_b = AW'(child2);
					end else begin
						state_d = bmh_pkg::S_PUT;
					end
				end else begin
					state_d = bmh_pkg::S_PUT;
				end
			end
			bmh_pkg::S_PUT: begin
				mem_we  = 1'b1;
				state_d = bmh_pkg::S_DONE;
			end
			bmh_pkg::S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = bmh_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bmh_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
		end
		key_q     <= key_d;
		hole_q    <= hole_d;
		stat_q    <= stat_d;
		rem_q     <= rem_d;
		rem_vld_q <= rem_vld_d;
		// The root is mirrored in a register so the minimum is always at hand.
		if (mem_we && mem_waddr == '0) begin
			root_q <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			heap_mem[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= heap_mem[rd_addr_a];
		rd_b_q <= heap_mem[rd_addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q  <= stat_q;
			out_removed_q <= bmh_pkg::PORT_KEY_W'(rem_q);
			out_rvld_q    <= rem_vld_q;
			out_count_q   <= bmh_pkg::PORT_CNT_W'(cnt_q);
			out_min_q     <= (cnt_q == '0) ? bmh_pkg::EMPTY_MIN : bmh_pkg::PORT_KEY_W'(root_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign removed_key   = out_removed_q;
	assign removed_valid = out_rvld_q;
	assign entry_count   = out_count_q;
	assign min_key       = out_min_q;

endmodule

[design/bmh_checker.sv]
module bmh_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic [1:0]                            status,
	input logic signed [bmh_pkg::PORT_KEY_W-1:0] removed_key,
	input logic                                  removed_valid,
	input logic [bmh_pkg::PORT_CNT_W-1:0]        entry_count,
	input logic signed [bmh_pkg::PORT_KEY_W-1:0] min_key
);

	// A stalled word stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(removed_key)
			&& $stable(entry_count) && $stable(min_key))
		else $error("output word changed while stalled");

	// An empty heap reports the empty minimum.
	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_count == '0 |-> min_key == bmh_pkg::EMPTY_MIN)
		else $error("empty heap with a minimum other than -1");

	// A removed key only comes with a successful status, and none otherwise reads zero.
	a_removed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && removed_valid |-> status == bmh_pkg::ST_OK)
		else $error("removed key with an error status");

	a_removed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !removed_valid |-> removed_key == '0)
		else $error("removed key not zero without a removal");

	// A dropped insert only happens on a full heap.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == bmh_pkg::ST_FULL
			|-> entry_count == bmh_pkg::PORT_CNT_W'(bmh_pkg::CAPACITY))
		else $error("full status with heap not full");

endmodule

bind binary_min_heap_priority_queue bmh_checker u_bmh_checker (.*);
